// ----- design/coc_pkg.sv -----
`timescale 1ns / 1ps

package coc_pkg;

  // Default store depth and screen extent.
  localparam int unsigned SHAPE_WORDS_DEF = 4096;
  localparam int unsigned COORD_MAX_DEF   = 4096;

  // Field widths.
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned DIFF_W     = 14;
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned HEIGHT_W   = 10;
  localparam int unsigned PITCH_W    = 11;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Byte address into the shape store before wrapping.
  localparam int unsigned BYTE_AW = 21;

  // Pixel constants.
  localparam logic [PIX_W-1:0] RGB_MASK     = 32'h00FF_FFFF;
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURSOR_LEFT      = 3'd0,
    CFG_CURSOR_TOP       = 3'd1,
    CFG_SHAPE_WIDTH      = 3'd2,
    CFG_SHAPE_HEIGHT_RAW = 3'd3,
    CFG_SHAPE_PITCH      = 3'd4,
    CFG_SHAPE_KIND       = 3'd5,
    CFG_CURSOR_ENABLE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_COLOR  = 2'd0,
    KIND_MASKED = 2'd1,
    KIND_MONO   = 2'd2
  } shape_kind_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_WRITE = 1'b1
  } item_mode_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [POS_W-1:0]    cursor_left;
    logic [POS_W-1:0]    cursor_top;
    logic [WIDTH_W-1:0]  shape_width;
    logic [HEIGHT_W-1:0] shape_height_raw;
    logic [PITCH_W-1:0]  shape_pitch;
    logic [KIND_W-1:0]   shape_kind;
    logic                cursor_enable;
  } cfg_t;

  // Byte lanes of the two shape words used by monochrome shapes.
  typedef struct packed {
    logic [1:0] lane_a;
    logic [1:0] lane_b;
  } lanes_t;

endpackage

// ----- design/coc_if.sv -----
`timescale 1ns / 1ps

// Input channel: one pixel to composite or one shape word to store.
interface coc_in_if;
  import coc_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [PIX_W-1:0]   screen_pixel;
  logic [IDX_W-1:0]   shape_index;
  logic [PIX_W-1:0]   shape_word;

  modport source (
    output valid, mode, pixel_x, pixel_y, screen_pixel, shape_index, shape_word,
    input  ready
  );
  modport sink (
    input  valid, mode, pixel_x, pixel_y, screen_pixel, shape_index, shape_word,
    output ready
  );
endinterface

// Output channel: one composited pixel.
interface coc_out_if;
  import coc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             in_cursor;

  modport source (
    output valid, out_pixel, in_cursor,
    input  ready
  );
  modport sink (
    input  valid, out_pixel, in_cursor,
    output ready
  );
endinterface

// ----- design/coc_ram.sv -----
`timescale 1ns / 1ps

module coc_ram #(
  parameter int unsigned WIDTH = coc_pkg::PIX_W,
  parameter int unsigned DEPTH = coc_pkg::SHAPE_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port; the read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/coc_cfg.sv -----
`timescale 1ns / 1ps

module coc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [coc_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [coc_pkg::CFG_DATA_W-1:0]  data_i,
  output coc_pkg::cfg_t                   cfg_o
);
  import coc_pkg::*;

  cfg_t cfg_q;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_CURSOR_LEFT:      cfg_q.cursor_left      <= data_i[POS_W-1:0];
        CFG_CURSOR_TOP:       cfg_q.cursor_top       <= data_i[POS_W-1:0];
        CFG_SHAPE_WIDTH:      cfg_q.shape_width      <= data_i[WIDTH_W-1:0];
        CFG_SHAPE_HEIGHT_RAW: cfg_q.shape_height_raw <= data_i[HEIGHT_W-1:0];
        CFG_SHAPE_PITCH:      cfg_q.shape_pitch      <= data_i[PITCH_W-1:0];
        CFG_SHAPE_KIND:       cfg_q.shape_kind       <= data_i[KIND_W-1:0];
        CFG_CURSOR_ENABLE:    cfg_q.cursor_enable    <= data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/coc_addr.sv -----
`timescale 1ns / 1ps

module coc_addr #(
  parameter int unsigned SHAPE_WORDS = coc_pkg::SHAPE_WORDS_DEF
) (
  input  coc_pkg::cfg_t                   cfg_i,
  input  logic [coc_pkg::WIDTH_W-1:0]     col_i,
  input  logic [coc_pkg::HEIGHT_W-1:0]    row_i,
  output logic [$clog2(SHAPE_WORDS)-1:0]  addr_a_o,
  output logic [$clog2(SHAPE_WORDS)-1:0]  addr_b_o,
  output coc_pkg::lanes_t                 lanes_o
);
  import coc_pkg::*;

  localparam int unsigned AW = $clog2(SHAPE_WORDS);

  logic                  mono;
  logic [PITCH_W-1:0]    row_stride;
  logic [HEIGHT_W-2:0]   half_height;
  logic [BYTE_AW-1:0]    row_base;
  logic [BYTE_AW-1:0]    plane_offset;
  logic [BYTE_AW-1:0]    color_word;
  logic [BYTE_AW-1:0]    and_byte;
  logic [BYTE_AW-1:0]    xor_byte;

  // Color shapes step in words, monochrome planes in bytes.
  assign mono        = (cfg_i.shape_kind == KIND_MONO);
  assign row_stride  = mono ? cfg_i.shape_pitch : {2'b00, cfg_i.shape_pitch[PITCH_W-1:2]};
  assign half_height = cfg_i.shape_height_raw[HEIGHT_W-1:1];

  // Row base and the distance from the AND plane to the XOR plane.
  assign row_base     = BYTE_AW'(row_i) * BYTE_AW'(row_stride);
  assign plane_offset = BYTE_AW'(half_height) * BYTE_AW'(cfg_i.shape_pitch);

  assign color_word = row_base + BYTE_AW'(col_i);
  assign and_byte   = row_base + BYTE_AW'(col_i[WIDTH_W-1:3]);
  assign xor_byte   = and_byte + plane_offset;

  // Store addresses wrap at the store depth.
  assign addr_a_o = mono ? and_byte[AW+1:2] : color_word[AW-1:0];
  assign addr_b_o = xor_byte[AW+1:2];

  assign lanes_o.lane_a = and_byte[1:0];
  assign lanes_o.lane_b = xor_byte[1:0];

endmodule

// ----- design/coc_blend.sv -----
`timescale 1ns / 1ps

module coc_blend (
  input  logic [coc_pkg::KIND_W-1:0] kind_i,
  input  logic                       hit_i,
  input  logic [coc_pkg::PIX_W-1:0]  screen_i,
  input  logic [coc_pkg::PIX_W-1:0]  word_a_i,
  input  logic [coc_pkg::PIX_W-1:0]  word_b_i,
  input  coc_pkg::lanes_t            lanes_i,
  input  logic [2:0]                 col_i,
  output logic [coc_pkg::PIX_W-1:0]  pixel_o
);
  import coc_pkg::*;

  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic       and_bit;
  logic       xor_bit;

  // Monochrome bits are stored most significant first within a byte.
  assign byte_a  = word_a_i[{lanes_i.lane_a, 3'b000} +: 8];
  assign byte_b  = word_b_i[{lanes_i.lane_b, 3'b000} +: 8];
  assign and_bit = byte_a[~col_i];
  assign xor_bit = byte_b[~col_i];

  // Blend by shape kind; pixels outside the cursor pass through.
  always_comb begin
    pixel_o = screen_i;
    if (hit_i) begin
      case (kind_i)
        KIND_COLOR: begin
          if (word_a_i[PIX_W-1]) begin
            pixel_o = word_a_i;
          end
        end
        KIND_MASKED: begin
          if (!word_a_i[PIX_W-1]) begin
            pixel_o = (word_a_i & RGB_MASK) | ALPHA_OPAQUE;
          end else begin
            pixel_o = screen_i ^ (word_a_i & RGB_MASK);
          end
        end
        KIND_MONO: begin
          pixel_o = (screen_i & (and_bit ? ALL_ONES : ALPHA_OPAQUE))
                    ^ (xor_bit ? RGB_MASK : '0);
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- design/cursor_overlay_compositor.sv -----
`timescale 1ns / 1ps

// Cursor overlay compositor.
// Items arrive on pix_in_i. A pixel item (mode 0) carries a screen position
// and a BGRA pixel and yields one composited pixel on pix_out_o, with
// in_cursor set when the pixel lay inside the visible cursor rectangle.
// A write item (mode 1) stores one shape word and yields nothing.
// Registers are written via cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write them only while no item is in flight; the block does not check it.
// A pixel passes through the address stage, the memory read stage and the
// output register in order. Throughput is one item per cycle while ready is
// high: each item makes one access to each of two mirrored single-port shape
// memories. A stalled output keeps its result; the two stages behind it still
// take items, so ready drops only once all three hold items.
// Reset clears the registers and empties the pipeline. The shape memories
// are not cleared and hold no defined data until written.
// SHAPE_WORDS must be a power of two.
module cursor_overlay_compositor #(
  parameter int unsigned SHAPE_WORDS = coc_pkg::SHAPE_WORDS_DEF,
  parameter int unsigned COORD_MAX   = coc_pkg::COORD_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  coc_in_if.sink                          pix_in_i,
  coc_out_if.source                       pix_out_o,
  input  logic                            cfg_we_i,
  input  logic [coc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [coc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import coc_pkg::*;

  localparam int unsigned AW = $clog2(SHAPE_WORDS);

  cfg_t cfg;

  // Hit test signals.
  logic [DIFF_W-1:0]   cx;
  logic [DIFF_W-1:0]   cy;
  logic [HEIGHT_W-1:0] vis_height;
  logic                kind_ok;
  logic                on_screen;
  logic                hit_s0;

  // Handshake and stage control.
  logic in_ready;
  logic out_free;
  logic s2_adv;
  logic s1_move;

  // Address stage.
  logic                s1_valid_q;
  logic                s1_write_q;
  logic [IDX_W-1:0]    s1_widx_q;
  logic [PIX_W-1:0]    s1_wval_q;
  logic [PIX_W-1:0]    s1_scr_q;
  logic                s1_hit_q;
  logic [WIDTH_W-1:0]  s1_col_q;
  logic [HEIGHT_W-1:0] s1_row_q;
  logic                s1_wr_ok;

  // Memory access.
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  lanes_t           lanes;
  logic [AW-1:0]    ram_addr_a;
  logic [AW-1:0]    ram_addr_b;
  logic             ram_we;
  logic             ram_re;
  logic [PIX_W-1:0] word_a;
  logic [PIX_W-1:0] word_b;

  // Memory read stage.
  logic             s2_valid_q;
  logic             s2_hit_q;
  logic [PIX_W-1:0] s2_scr_q;
  lanes_t           s2_lanes_q;
  logic [2:0]       s2_col_q;
  logic [PIX_W-1:0] blend_pixel;

  // Output register.
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_in_cursor_q;

  coc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Position relative to the cursor and the rectangle test.
  assign cx = {2'b00, pix_in_i.pixel_x} - {cfg.cursor_left[POS_W-1], cfg.cursor_left};
  assign cy = {2'b00, pix_in_i.pixel_y} - {cfg.cursor_top[POS_W-1], cfg.cursor_top};
  assign vis_height = (cfg.shape_kind == KIND_MONO)
                      ? {1'b0, cfg.shape_height_raw[HEIGHT_W-1:1]}
                      : cfg.shape_height_raw;
  assign kind_ok = (cfg.shape_kind == KIND_COLOR) || (cfg.shape_kind == KIND_MASKED)
                   || (cfg.shape_kind == KIND_MONO);
  assign on_screen = (32'(pix_in_i.pixel_x) < 32'(COORD_MAX))
                     && (32'(pix_in_i.pixel_y) < 32'(COORD_MAX));
  assign hit_s0 = cfg.cursor_enable && kind_ok && on_screen
                  && !cx[DIFF_W-1] && (cx[DIFF_W-2:0] < (DIFF_W-1)'(cfg.shape_width))
                  && !cy[DIFF_W-1] && (cy[DIFF_W-2:0] < (DIFF_W-1)'(vis_height));

  // Stage control: a write retires from the address stage on its own.
  assign out_free = !out_valid_q || pix_out_o.ready;
  assign s2_adv   = !s2_valid_q || out_free;
  assign s1_move  = s1_write_q || s2_adv;
  assign in_ready = !s1_valid_q || s1_move;
  assign pix_in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= pix_in_i.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q && !s1_write_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Address stage payload.
  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      s1_write_q <= (pix_in_i.mode == MODE_WRITE);
      s1_widx_q  <= pix_in_i.shape_index;
      s1_wval_q  <= pix_in_i.shape_word;
      s1_scr_q   <= pix_in_i.screen_pixel;
      s1_hit_q   <= hit_s0;
      s1_col_q   <= cx[WIDTH_W-1:0];
      s1_row_q   <= cy[HEIGHT_W-1:0];
    end
  end

  coc_addr #(
    .SHAPE_WORDS (SHAPE_WORDS)
  ) u_addr (
    .cfg_i    (cfg),
    .col_i    (s1_col_q),
    .row_i    (s1_row_q),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .lanes_o  (lanes)
  );

  // Writes and reads leave the address stage in item order, one per cycle; a read waits while the read stage is held.
  assign s1_wr_ok   = 32'(s1_widx_q) < 32'(SHAPE_WORDS);
  assign ram_we     = s1_valid_q && s1_write_q && s1_wr_ok;
  assign ram_re     = s2_adv && s1_valid_q && !s1_write_q;
  assign ram_addr_a = s1_write_q ? AW'(s1_widx_q) : addr_a;
  assign ram_addr_b = s1_write_q ? AW'(s1_widx_q) : addr_b;

  // Two mirrored copies give the AND and XOR plane words in one read.
  coc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SHAPE_WORDS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr_a),
    .wdata_i (s1_wval_q),
    .rdata_o (word_a)
  );

  coc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SHAPE_WORDS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr_b),
    .wdata_i (s1_wval_q),
    .rdata_o (word_b)
  );

  // Memory read stage payload, aligned with the read data.
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_hit_q   <= s1_hit_q;
      s2_scr_q   <= s1_scr_q;
      s2_lanes_q <= lanes;
      s2_col_q   <= s1_col_q[2:0];
    end
  end

  coc_blend u_blend (
    .kind_i   (cfg.shape_kind),
    .hit_i    (s2_hit_q),
    .screen_i (s2_scr_q),
    .word_a_i (word_a),
    .word_b_i (word_b),
    .lanes_i  (s2_lanes_q),
    .col_i    (s2_col_q),
    .pixel_o  (blend_pixel)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      out_pixel_q     <= blend_pixel;
      out_in_cursor_q <= s2_hit_q;
    end
  end

  assign pix_out_o.valid     = out_valid_q;
  assign pix_out_o.out_pixel = out_pixel_q;
  assign pix_out_o.in_cursor = out_in_cursor_q;

  // The memory port serves one access per cycle.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("shape memory read and write in the same cycle");

  // Ready drops only when all three stages are full.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && s2_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // A write item never reaches the read stage.
  a_write_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_write_q && s2_adv) |=> !s2_valid_q)
    else $error("write item entered the read stage");

  // A pixel outside the cursor leaves unchanged.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_free && s2_valid_q && !s2_hit_q) |=> (out_pixel_q == $past(s2_scr_q)))
    else $error("pixel outside the cursor was modified");

endmodule
